// ===== rtl/vmv_pkg.sv =====
package vmv_pkg;

    // Character codes used by the message grammar
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Message lengths and positions, counted in characters from the first
    localparam logic [7:0] MAX_LEN_RESET = 8'd16;
    localparam logic [7:0] HR_MAX_LEN    = 8'd7;
    localparam logic [7:0] TEMP_BODY_POS = 8'd5;
    localparam logic [7:0] TEMP_DOT_POS  = 8'd7;
    localparam logic [7:0] TEMP_END_POS  = 8'd9;
    localparam logic [7:0] COUNT_SAT     = 8'hFF;

    // Digit group limits
    localparam logic [1:0] RUN_MIN = 2'd2;
    localparam logic [1:0] RUN_MAX = 2'd3;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

// ===== rtl/vital_message_validator.sv =====
// Vital-sign message checker. Characters arrive one per transfer on the input
// channel, the last one of each message flagged by i_is_last; that character
// produces a single verdict on o_valid_res (1 = well formed "BP:", "TEMP:" or
// "HR:" message). Unless stalled, one character is taken every cycle: the parser
// state advances in the cycle of the transfer and the verdict sits in one output
// register, so input and output can both move on every cycle and a verdict
// appears in the cycle after its last character. The input is stalled only while
// that output register is full and the output side stalls. max_length is
// written through i_cfg_wr_en/i_cfg_wr_data and should change only while idle.
module vital_message_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_valid_res
);
    import vmv_pkg::*;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_PRE_BP,
        MODE_PRE_TEMP,
        MODE_PRE_HR,
        MODE_BODY_BP,
        MODE_BODY_TEMP,
        MODE_BODY_HR,
        MODE_REJECT
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic [1:0] r_run, n_run;
    logic       r_slash, n_slash;
    logic [7:0] r_max_len;
    logic       r_out_valid;
    logic       r_out_res;
    logic       n_verdict;
    logic       accept;
    logic       dig;

    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_res;
    assign dig         = is_digit(i_char_code);

    always_comb begin
        n_mode  = r_mode;
        n_run   = r_run;
        n_slash = r_slash;
        unique case (r_mode)
            MODE_START: begin
                if (i_char_code == CH_B) n_mode = MODE_PRE_BP;
                else if (i_char_code == CH_T) n_mode = MODE_PRE_TEMP;
                else if (i_char_code == CH_H) n_mode = MODE_PRE_HR;
                else n_mode = MODE_REJECT;
            end
            MODE_PRE_BP: begin
                if (r_count == 8'd1 && i_char_code == CH_P) n_mode = MODE_PRE_BP;
                else if (r_count == 8'd2 && i_char_code == CH_COLON) n_mode = MODE_BODY_BP;
                else n_mode = MODE_REJECT;
            end
            MODE_PRE_TEMP: begin
                if (r_count == 8'd1 && i_char_code == CH_E) n_mode = MODE_PRE_TEMP;
                else if (r_count == 8'd2 && i_char_code == CH_M) n_mode = MODE_PRE_TEMP;
                else if (r_count == 8'd3 && i_char_code == CH_P) n_mode = MODE_PRE_TEMP;
                else if (r_count == 8'd4 && i_char_code == CH_COLON) n_mode = MODE_BODY_TEMP;
                else n_mode = MODE_REJECT;
            end
            MODE_PRE_HR: begin
                if (r_count == 8'd1 && i_char_code == CH_R) n_mode = MODE_PRE_HR;
                else if (r_count == 8'd2 && i_char_code == CH_COLON) n_mode = MODE_BODY_HR;
                else n_mode = MODE_REJECT;
            end
            MODE_BODY_BP: begin
                if (dig) begin
                    if (r_run == RUN_MAX) n_mode = MODE_REJECT;
                    else n_run = r_run + 2'd1;
                end else if (i_char_code == CH_SLASH && !r_slash) begin
                    if (r_run < RUN_MIN) begin
                        n_mode = MODE_REJECT;
                    end else begin
                        n_run   = 2'd0;
                        n_slash = 1'b1;
                    end
                end else begin
                    n_mode = MODE_REJECT;
                end
            end
            MODE_BODY_TEMP: begin
                // two digits, a dot, one digit
                if (r_count == TEMP_DOT_POS) begin
                    if (i_char_code != CH_DOT) n_mode = MODE_REJECT;
                end else if (r_count >= TEMP_BODY_POS && r_count < TEMP_END_POS) begin
                    if (!dig) n_mode = MODE_REJECT;
                end else begin
                    n_mode = MODE_REJECT;
                end
            end
            MODE_BODY_HR: begin
                if (!dig || r_run == RUN_MAX) n_mode = MODE_REJECT;
                else n_run = r_run + 2'd1;
            end
            MODE_REJECT: n_mode = MODE_REJECT;
            default:     n_mode = MODE_REJECT;
        endcase

        n_count = (r_count == COUNT_SAT) ? r_count : r_count + 8'd1;

        case (n_mode)
            MODE_BODY_BP:   n_verdict = n_slash && (n_run >= RUN_MIN) && (n_count <= r_max_len);
            MODE_BODY_TEMP: n_verdict = (n_count == TEMP_END_POS) && (n_count <= r_max_len);
            MODE_BODY_HR:   n_verdict = (n_run >= RUN_MIN) && (n_count <= HR_MAX_LEN);
            default:        n_verdict = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_START;
            r_count     <= 8'd0;
            r_run       <= 2'd0;
            r_slash     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_res   <= 1'b0;
        end else begin
            if (accept) begin
                if (i_is_last) begin
                    // verdict out, start the next message afresh
                    r_mode  <= MODE_START;
                    r_count <= 8'd0;
                    r_run   <= 2'd0;
                    r_slash <= 1'b0;
                end else begin
                    r_mode  <= n_mode;
                    r_count <= n_count;
                    r_run   <= n_run;
                    r_slash <= n_slash;
                end
            end
            if (accept && i_is_last) begin
                r_out_valid <= 1'b1;
                r_out_res   <= n_verdict;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/vmv_checker.sv =====
module vmv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_char_code,
    input logic       i_is_last,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_valid_res
);
    import vmv_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_valid_res))
        else $error("stalled verdict changed");

    // a last character always yields a verdict next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_last |=> o_valid)
        else $error("missing verdict");

    // a non-final character never yields one
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_is_last |=> !o_valid)
        else $error("verdict without last character");

    // every well formed message ends in a digit
    a_ends_in_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_last && !is_digit(i_char_code) |=> !o_valid_res)
        else $error("accepted message ending in a non-digit");

endmodule

bind vital_message_validator vmv_checker u_vmv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_char_code (i_char_code),
    .i_is_last   (i_is_last),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_valid_res (o_valid_res)
);
